>>> sv/b32e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol to ASCII mapping of the base32
// stream encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

   localparam int SYM_W   = 5;
   localparam int NUM_SYM = 3;
   localparam int CHAR_W  = 7;
   localparam int CNT_W   = 2;

   localparam logic [SYM_W-1:0]  LETTER_COUNT = 5'd26;
   localparam logic [CHAR_W-1:0] ASCII_A      = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_TWO    = 7'h32;

   // Symbols produced by one byte transfer, oldest in slot 0.
   typedef struct packed {
      logic [NUM_SYM-1:0][SYM_W-1:0] sym;
      logic [CNT_W-1:0]              count;
      logic                          last;
   } group_type;

   function automatic logic [CHAR_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] v);
      logic [CHAR_W-1:0] r;
      if (v < LETTER_COUNT) begin
         r = ASCII_A + {2'b00, v};
      end else begin
         r = ASCII_TWO + {2'b00, v - LETTER_COUNT};
      end
      return r;
   endfunction

endpackage

>>> sv/b32e_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_req_if
// Byte input channel: valid/ready handshake with byte and end marker.
// ----------------------------------------------------------------------------
interface b32e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/b32e_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_rsp_if
// Character output channel: valid/ready handshake with ASCII code and
// end marker.
// ----------------------------------------------------------------------------
interface b32e_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [b32e_pkg::CHAR_W-1:0]  char_code;
   logic                         last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> sv/b32e_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pack
// Splits the leftover bits plus the incoming byte into 5-bit symbols and
// keeps the leftover bit buffer between transfers.
// ----------------------------------------------------------------------------
module b32e_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output b32e_pkg::group_type grp
);

   logic [3:0]  leftover_bits_ff, leftover_bits_in;
   logic [2:0]  leftover_count_ff, leftover_count_in;

   logic [2:0]  cnt;
   logic [11:0] acc;
   logic [3:0]  total;
   logic        two_full;
   logic [2:0]  sh0;
   logic [1:0]  sh1;
   logic [2:0]  rem;
   logic [3:0]  rem_bits;
   logic [4:0]  pad_sym;

   always_comb begin
      cnt      = (leftover_count_ff > 3'd4) ? 3'd4 : leftover_count_ff;
      acc      = {leftover_bits_ff, data_byte};
      total    = {1'b0, cnt} + 4'd8;
      two_full = (total >= 4'd10);
      sh0      = 3'(total - 4'd5);
      sh1      = 2'(total - 4'd10);
      rem      = two_full ? 3'(total - 4'd10) : 3'(total - 4'd5);
      rem_bits = acc[3:0] & 4'((5'd1 << rem) - 5'd1);
      pad_sym  = 5'({1'b0, rem_bits} << (3'd5 - rem));

      grp.sym[0] = 5'(acc >> sh0);
      grp.sym[1] = two_full ? 5'(acc >> sh1) : pad_sym;
      grp.sym[2] = pad_sym;
      grp.last   = last_byte;
      if (last_byte && rem != 3'd0) begin
         grp.count = two_full ? 2'd3 : 2'd2;
      end else begin
         grp.count = two_full ? 2'd2 : 2'd1;
      end

      if (last_byte) begin
         leftover_bits_in  = 4'd0;
         leftover_count_in = 3'd0;
      end else begin
         leftover_bits_in  = rem_bits;
         leftover_count_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= 4'd0;
         leftover_count_ff <= 3'd0;
      end else if (take) begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      leftover_count_ff <= 3'd4)
      else $error("leftover count out of range");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      take && last_byte |=> leftover_count_ff == 3'd0 && leftover_bits_ff == 4'd0)
      else $error("buffer not cleared after last byte");

endmodule

>>> sv/b32e_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_drain
// Holds the symbol group of one transfer and sends its characters one per
// cycle through the output register while the receiver keeps ready high.
// ----------------------------------------------------------------------------
module b32e_drain (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  b32e_pkg::group_type         grp_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [b32e_pkg::CHAR_W-1:0] rsp_char_code,
   output logic                        rsp_last_char
);

   b32e_pkg::group_type         grp_ff;
   logic                        grp_valid_ff;
   logic [b32e_pkg::CNT_W-1:0]  idx_ff;
   logic                        out_valid_ff;
   logic [b32e_pkg::CHAR_W-1:0] out_code_ff;
   logic                        out_last_ff;

   logic out_free, move, grp_done, accept;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign move      = grp_valid_ff && out_free;
   assign grp_done  = move && (idx_ff == grp_ff.count - 2'd1);
   assign req_ready = !grp_valid_ff || grp_done;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            grp_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end else if (grp_done) begin
            grp_valid_ff <= 1'b0;
         end else if (move) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grp_ff <= grp_in;
      end
      if (move) begin
         out_code_ff <= b32e_pkg::sym_to_ascii(grp_ff.sym[idx_ff]);
         out_last_ff <= grp_ff.last && grp_done;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_code_ff;
   assign rsp_last_char = out_last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> idx_ff < grp_ff.count)
      else $error("symbol index past group size");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> grp_valid_ff && idx_ff == '0)
      else $error("group not loaded on transfer");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      grp_done && grp_ff.last |=> out_valid_ff && out_last_ff)
      else $error("final character not marked");

endmodule

>>> sv/base32_stream_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_stream_encoder_unit
// Lowercase unpadded base32 encoder, one byte per transfer in, one
// character per transfer out.
// ----------------------------------------------------------------------------
// The first character of a byte is offered once it has passed the group
// register and then the output register. A byte yields 1 to 3 characters
// (1.6 on average), sent one per cycle while the receiver keeps ready high.
// A new byte is taken in the cycle its group's last character moves out.
// Reset (synchronous, active high) clears the leftover buffer and all valids.
module base32_stream_encoder_unit (
   input  logic             clock,
   input  logic             reset,
   b32e_req_if.sink         req_chan,
   b32e_rsp_if.source       rsp_chan
);

   b32e_pkg::group_type grp;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   b32e_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .take      (req_chan.valid && req_ready),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .grp       (grp)
   );

   b32e_drain u_drain (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_ready),
      .grp_in        (grp),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_char_code (rsp_chan.char_code),
      .rsp_last_char (rsp_chan.last_char)
   );

endmodule
